// ===== src/kce_pkg.sv =====
// Shared types, constants and helpers for the canonical k-mer extractor.
package kce_pkg;

	localparam int unsigned MAX_K_DEF  = 32;
	localparam int unsigned BASE_W     = 2;
	localparam int unsigned KMER_W     = 64;
	localparam int unsigned KMER_LEN_W = 6;
	localparam logic [KMER_LEN_W-1:0] KMER_LEN_RST = 6'd31;

	typedef logic [BASE_W-1:0] base_t;

	typedef struct packed {
		base_t base_code;
		logic  last_base;
	} base_word_t;

	typedef struct packed {
		logic [KMER_W-1:0] canonical_kmer;
		logic              took_reverse;
		logic              sequence_end;
	} kmer_word_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	function automatic base_t base_comp(input base_t b);
		return ~b;
	endfunction

endpackage

// ===== src/kce_cell.sv =====
// One window cell: a forward base and a reverse-complement base, shifted or cleared together.
module kce_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kce_pkg::cell_ctrl_t   ctrl,
	input  logic [kce_pkg::BASE_W-1:0] fwd_in,
	input  logic [kce_pkg::BASE_W-1:0] rev_in,
	output logic [kce_pkg::BASE_W-1:0] fwd,
	output logic [kce_pkg::BASE_W-1:0] rev
);
	import kce_pkg::*;

	base_t fwd_q;
	base_t rev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rev_q <= '0;
		end else if (ctrl.shift) begin
			if (ctrl.clear) begin
				fwd_q <= '0;
				rev_q <= '0;
			end else begin
				fwd_q <= fwd_in;
				rev_q <= rev_in;
			end
		end
	end

	assign fwd = fwd_q;
	assign rev = rev_q;

endmodule

// ===== src/canonical_kmer_extractor.sv =====
// Top level of the canonical k-mer extractor: cell chain, alignment and compare pipeline.
// Takes one base per cycle while base_ready is high and, once k bases of the current
// sequence have arrived (k is kmer_length, 0 read as 1, capped at MAX_K), gives one
// canonical k-mer word per base. The window is a chain of MAX_K cells that all shift on
// each accepted base; the following stages align the reverse-complement window to k,
// mask both windows and compare them. Every stage has its own valid bit, so bases keep
// flowing into empty stages while a finished word waits at the output. kmer_length is
// sampled per base and may only be written while no word is in flight.
module canonical_kmer_extractor #(
	parameter int unsigned MAX_K = kce_pkg::MAX_K_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               base_valid,
	output logic                               base_ready,
	input  kce_pkg::base_word_t                base_word,
	output logic                               kmer_valid,
	input  logic                               kmer_ready,
	output kce_pkg::kmer_word_t                kmer_word,
	input  logic                               cfg_we,
	input  logic [kce_pkg::KMER_LEN_W-1:0]     cfg_wdata
);
	import kce_pkg::*;

	localparam int unsigned WIN_W = 2 * MAX_K;
	localparam int unsigned CNT_W = $clog2(MAX_K + 1);

	logic [KMER_LEN_W-1:0] len_q;
	logic [CNT_W-1:0]      k_eff;
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      fill_nx;
	logic                  emit;
	logic                  accept;

	cell_ctrl_t cell_ctrl;
	base_t      fwd_d    [MAX_K];
	base_t      rev_d    [MAX_K];
	base_t      fwd_in_d [MAX_K];
	base_t      rev_in_d [MAX_K];
	logic [WIN_W-1:0] fwd_nx;
	logic [WIN_W-1:0] rev_nx;

	logic             s1_v;
	logic [WIN_W-1:0] fwd_s1;
	logic [WIN_W-1:0] rev_s1;
	logic [CNT_W-1:0] k_s1;
	logic             last_s1;

	logic             s2_v;
	logic [WIN_W-1:0] fwd_s2;
	logic [WIN_W-1:0] rev_s2;
	logic             last_s2;

	logic [CNT_W:0]   rev_shamt;
	logic [WIN_W-1:0] rev_sh;
	logic [WIN_W-1:0] keep_mask;

	logic       out_v_q;
	kmer_word_t out_word_q;
	logic       took;

	logic out_free;
	logic s2_free;
	logic s1_free;

	assign out_free   = !out_v_q || kmer_ready;
	assign s2_free    = !s2_v || out_free;
	assign s1_free    = !s1_v || s2_free;
	assign base_ready = s1_free;
	assign accept     = base_valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= KMER_LEN_RST;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (len_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (len_q > KMER_LEN_W'(MAX_K)) begin
			k_eff = CNT_W'(MAX_K);
		end else begin
			k_eff = CNT_W'(len_q);
		end
	end

	assign fill_nx = (fill_q == CNT_W'(MAX_K)) ? fill_q : fill_q + CNT_W'(1);
	assign emit    = fill_nx >= k_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= base_word.last_base ? '0 : fill_nx;
		end
	end

	assign cell_ctrl.shift = accept;
	assign cell_ctrl.clear = base_word.last_base;

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign fwd_in_d[i] = base_word.base_code;
		end else begin : g_fwd
			assign fwd_in_d[i] = fwd_d[i-1];
		end
		if (i == MAX_K - 1) begin : g_tail
			assign rev_in_d[i] = base_comp(base_word.base_code);
		end else begin : g_rev
			assign rev_in_d[i] = rev_d[i+1];
		end

		kce_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.fwd_in (fwd_in_d[i]),
			.rev_in (rev_in_d[i]),
			.fwd    (fwd_d[i]),
			.rev    (rev_d[i])
		);

		assign fwd_nx[2*i +: 2] = fwd_in_d[i];
		assign rev_nx[2*i +: 2] = rev_in_d[i];
		assign keep_mask[2*i +: 2] = {2{CNT_W'(i) < k_s1}};
	end

	// stage 1: capture the shifted windows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s1_free) begin
			s1_v <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_s1  <= fwd_nx;
			rev_s1  <= rev_nx;
			k_s1    <= k_eff;
			last_s1 <= base_word.last_base;
		end
	end

	// stage 2: align reverse window to k and mask
	assign rev_shamt = (CNT_W + 1)'(MAX_K) - {1'b0, k_s1};
	assign rev_sh    = rev_s1 >> {rev_shamt, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_free) begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v && s2_free) begin
			fwd_s2  <= fwd_s1 & keep_mask;
			rev_s2  <= rev_sh & keep_mask;
			last_s2 <= last_s1;
		end
	end

	// output register: pick the smaller k-mer
	assign took = rev_s2 < fwd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_v && out_free) begin
			out_word_q.canonical_kmer <= KMER_W'(took ? rev_s2 : fwd_s2);
			out_word_q.took_reverse   <= took;
			out_word_q.sequence_end   <= last_s2;
		end
	end

	assign kmer_valid = out_v_q;
	assign kmer_word  = out_word_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_K))
		else $error("fill count above window depth");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && base_word.last_base |=> fill_q == '0)
		else $error("fill count not cleared after last base");

	a_emit_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_v == $past(emit))
		else $error("stage 1 valid does not match emit decision");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && !s2_free |=> s1_v && $stable(fwd_s1) && $stable(rev_s1))
		else $error("stage 1 lost data under stall");
`endif

endmodule

// ===== tb/canonical_kmer_extractor_tb.sv =====
// Testbench for the canonical k-mer extractor: directed and random sequences, self-checking.
module canonical_kmer_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kce_pkg::*;

	localparam int MAXK = MAX_K_DEF;
	localparam base_t BASE_A = 2'd0;
	localparam base_t BASE_C = 2'd1;
	localparam base_t BASE_G = 2'd2;
	localparam base_t BASE_T = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  base_valid;
	logic                  base_ready;
	base_word_t            base_word;
	logic                  kmer_valid;
	logic                  kmer_ready;
	kmer_word_t            kmer_word;
	logic                  cfg_we;
	logic [KMER_LEN_W-1:0] cfg_wdata;

	logic [KMER_LEN_W-1:0] kmer_len;
	logic [KMER_W-1:0]     fwd_bases;
	logic [KMER_W-1:0]     rc_bases;
	int                    bases_seen;
	kmer_word_t            kmer_expected[$];
	int                    mismatches;
	int                    rx_hold;
	bit                    rx_stalls;
	bit                    tx_gaps;

	canonical_kmer_extractor #(.MAX_K(MAXK)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_valid(base_valid),
		.base_ready(base_ready),
		.base_word (base_word),
		.kmer_valid(kmer_valid),
		.kmer_ready(kmer_ready),
		.kmer_word (kmer_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#20_000_000;
		$display("FAIL canonical_kmer_extractor");
		$finish;
	end

	function automatic int used_len();
		if (kmer_len == 0)
			return 1;
		if (kmer_len > MAXK)
			return MAXK;
		return int'(kmer_len);
	endfunction

	function automatic void predict_base(base_t b, logic last);
		logic [KMER_W-1:0] mask;
		logic [KMER_W-1:0] fwd;
		logic [KMER_W-1:0] rc;
		kmer_word_t        w;
		int                k;
		k = used_len();
		fwd_bases = {fwd_bases[KMER_W-3:0], b};
		rc_bases = {~b, rc_bases[KMER_W-1:2]};
		if (bases_seen < MAXK)
			bases_seen++;
		if (bases_seen >= k) begin
			mask = (k == MAXK) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
			fwd = fwd_bases & mask;
			rc = (rc_bases >> (2 * (MAXK - k))) & mask;
			w.canonical_kmer = (rc < fwd) ? rc : fwd;
			w.took_reverse = (rc < fwd);
			w.sequence_end = last;
			kmer_expected.insert(kmer_expected.size(), w);
		end
		if (last) begin
			fwd_bases = '0;
			rc_bases = '0;
			bases_seen = 0;
		end
	endfunction

	task automatic report_mismatch(string what, logic [KMER_W-1:0] got, logic [KMER_W-1:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		kmer_word_t want;
		if (arst_n && kmer_valid && kmer_ready) begin
			if (kmer_expected.size() == 0) begin
				report_mismatch("unexpected word", kmer_word.canonical_kmer, '0);
			end else begin
				want = kmer_expected.pop_front();
				if (kmer_word.canonical_kmer !== want.canonical_kmer)
					report_mismatch("canonical_kmer", kmer_word.canonical_kmer,
						want.canonical_kmer);
				if (kmer_word.took_reverse !== want.took_reverse)
					report_mismatch("took_reverse", kmer_word.took_reverse, want.took_reverse);
				if (kmer_word.sequence_end !== want.sequence_end)
					report_mismatch("sequence_end", kmer_word.sequence_end, want.sequence_end);
			end
		end
	end

	initial begin
		kmer_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				kmer_ready = 1'b0;
				rx_hold--;
			end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
				kmer_ready = 1'b0;
				rx_hold = ($urandom_range(0, 9) == 0) ?
					$urandom_range(8, 30) : $urandom_range(0, 2);
			end else begin
				kmer_ready = 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (!tx_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_base(base_t b, logic last);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			base_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		base_valid = 1'b1;
		base_word = '{base_code: b, last_base: last};
		@(posedge clk);
		while (!base_ready) @(posedge clk);
		predict_base(b, last);
	endtask

	task automatic drain_results();
		@(negedge clk);
		base_valid = 1'b0;
		while (kmer_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_kmer_length(logic [KMER_LEN_W-1:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		kmer_len = v;
	endtask

	task automatic run_sequences(int budget);
		base_t seq[$];
		base_t b;
		int    sent;
		int    len;
		int    k;
		int    kind;
		sent = 0;
		k = used_len();
		while (sent < budget) begin
			seq.delete();
			kind = $urandom_range(0, 7);
			if (kind == 0) begin
				len = $urandom_range(1, k);
				repeat (len) seq.insert(seq.size(), base_t'($urandom_range(0, 3)));
			end else if (kind == 1) begin
				repeat (k / 2) seq.insert(seq.size(), base_t'($urandom_range(0, 3)));
				for (int i = k / 2 - 1; i >= 0; i--)
					seq.insert(seq.size(), ~seq[i]);
				if (k % 2)
					seq.insert(seq.size(), base_t'($urandom_range(0, 3)));
			end else if (kind == 2) begin
				b = base_t'($urandom_range(0, 3));
				repeat (k + $urandom_range(0, 8)) seq.insert(seq.size(), b);
			end else begin
				len = k + $urandom_range(0, (k < 8) ? 24 : 2 * k);
				repeat (len) seq.insert(seq.size(), base_t'($urandom_range(0, 3)));
			end
			foreach (seq[i])
				send_base(seq[i], i == seq.size() - 1);
			sent += seq.size();
		end
		if ($urandom_range(0, 1))
			repeat ($urandom_range(1, 5)) send_base(base_t'($urandom_range(0, 3)), 1'b0);
	endtask

	task automatic test_reset_length();
		rx_stalls = 1'b1;
		tx_gaps = 1'b1;
		run_sequences(100);
		drain_results();
	endtask

	task automatic test_directed_cases();
		rx_stalls = 1'b0;
		tx_gaps = 1'b0;
		write_kmer_length(6'd1);
		send_base(BASE_A, 1'b1);
		send_base(BASE_C, 1'b1);
		send_base(BASE_G, 1'b1);
		send_base(BASE_T, 1'b1);
		drain_results();
		write_kmer_length(6'd2);
		send_base(BASE_A, 1'b0);
		send_base(BASE_T, 1'b1);
		drain_results();
		write_kmer_length(6'd0);
		send_base(BASE_G, 1'b0);
		send_base(BASE_C, 1'b1);
		drain_results();
		write_kmer_length(6'd4);
		send_base(BASE_C, 1'b0);
		send_base(BASE_G, 1'b0);
		send_base(BASE_A, 1'b1);
		drain_results();
		write_kmer_length(6'd63);
		send_base(BASE_T, 1'b0);
		send_base(BASE_T, 1'b1);
		drain_results();
		write_kmer_length(6'd3);
		send_base(BASE_A, 1'b0);
		send_base(BASE_C, 1'b0);
		drain_results();
		write_kmer_length(6'd2);
		send_base(BASE_G, 1'b0);
		send_base(BASE_T, 1'b1);
		drain_results();
	endtask

	task automatic test_random_lengths();
		logic [KMER_LEN_W-1:0] lengths[$];
		lengths = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd2, 6'd5, 6'd16, 6'd31, 6'd7};
		foreach (lengths[i]) begin
			drain_results();
			write_kmer_length((i == lengths.size() - 1) ?
				KMER_LEN_W'($urandom_range(0, 63)) : lengths[i]);
			tx_gaps = (i % 3 != 0);
			rx_stalls = (i % 4 != 1);
			run_sequences(95);
		end
		drain_results();
	endtask

	task automatic test_output_backpressure();
		write_kmer_length(6'd5);
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		rx_hold = 300;
		run_sequences(80);
		drain_results();
	endtask

	task automatic test_sender_pause();
		write_kmer_length(6'd8);
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		repeat (5) begin
			run_sequences(25);
			drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		base_valid = 1'b0;
		base_word = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		kmer_len = KMER_LEN_RST;
		fwd_bases = '0;
		rc_bases = '0;
		bases_seen = 0;
		mismatches = 0;
		rx_hold = 0;
		rx_stalls = 1'b0;
		tx_gaps = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_reset_length();
		test_directed_cases();
		test_random_lengths();
		test_output_backpressure();
		test_sender_pause();
		drain_results();
		if (mismatches == 0)
			$display("PASS canonical_kmer_extractor");
		else
			$display("FAIL canonical_kmer_extractor");
		$finish;
	end

endmodule
